// File: sv/ogru_pkg.sv
// ============================================================================
// ogru_pkg: shared types and constants for the occupancy grid ray update
// Action codes, register indexes, field widths, controller states and the
// command/status structs that join the controller and the datapath.
// ============================================================================
package ogru_pkg;

    localparam int ACT_W    = 2;
    localparam int COORD_W  = 11;
    localparam int ODDS_W   = 8;
    localparam int CNT_W    = 12;
    localparam int GAIN_W   = 7;
    localparam int SIZE_W   = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 9;

    localparam logic [ACT_W-1:0] ACT_ENDPOINT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RAY      = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HIT_ODDS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_ODDS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd3;

    localparam logic [GAIN_W-1:0] HIT_ODDS_RST    = 7'd3;
    localparam logic [GAIN_W-1:0] MISS_ODDS_RST   = 7'd1;
    localparam logic [SIZE_W-1:0] GRID_WIDTH_RST  = 9'd256;
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RST = 9'd256;

    localparam logic signed [ODDS_W-1:0] ODDS_MAX = 8'sd127;
    localparam logic signed [ODDS_W-1:0] ODDS_MIN = -8'sd127;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PT_RD,
        ST_PT_WR,
        ST_RAY_CHK,
        ST_RAY_RD,
        ST_RAY_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic pt_upd;
        logic ray_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_done;
        logic at_end;
        logic next_at_end;
    } t_dp_status;

endpackage

// File: sv/ogru_ctrl.sv
// ============================================================================
// ogru_ctrl: controller of the occupancy grid ray update
// Sequences the clearing pass, point updates, the ray walk and the result
// register, and drives the datapath through command signals.
// ============================================================================
module ogru_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ogru_pkg::ACT_W-1:0]  i_action,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  ogru_pkg::t_dp_status        i_status,
    output ogru_pkg::t_dp_cmd           o_cmd
);
    import ogru_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_status.clr_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        ACT_ENDPOINT: n_state = ST_PT_RD;
                        ACT_READ:     n_state = ST_PT_RD;
                        ACT_RAY:      n_state = ST_RAY_CHK;
                        default:      n_state = ST_DONE;
                    endcase
                end
            end
            ST_PT_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_PT_WR;
            end
            ST_PT_WR: begin
                o_cmd.pt_upd = 1'b1;
                n_state      = ST_DONE;
            end
            ST_RAY_CHK: begin
                n_state = i_status.at_end ? ST_DONE : ST_RAY_RD;
            end
            ST_RAY_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_RAY_WR;
            end
            ST_RAY_WR: begin
                o_cmd.ray_step = 1'b1;
                n_state        = i_status.next_at_end ? ST_DONE : ST_RAY_RD;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted while a request is in flight");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr, o_cmd.load, o_cmd.rd, o_cmd.pt_upd, o_cmd.ray_step,
                  o_cmd.out_load}))
        else $error("more than one datapath command at once");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

endmodule

// File: sv/ogru_dp.sv
// ============================================================================
// ogru_dp: datapath of the occupancy grid ray update
// Holds the configuration registers, the log-odds grid memory with its
// clearing counter, the Bresenham walk registers and the result registers.
// ============================================================================
module ogru_dp #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ogru_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [ogru_pkg::ACT_W-1:0]          i_action,
    input  logic signed [ogru_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [ogru_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [ogru_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [ogru_pkg::COORD_W-1:0] i_end_y,
    input  logic                                i_endpoint_in_range,
    input  ogru_pkg::t_dp_cmd                   i_cmd,
    output ogru_pkg::t_dp_status                o_status,
    output logic signed [ogru_pkg::ODDS_W-1:0]  o_cell_odds,
    output logic [ogru_pkg::CNT_W-1:0]          o_cells_written
);
    import ogru_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CWX   = ($clog2(MAX_WIDTH + 1) > 10) ? $clog2(MAX_WIDTH + 1) : 10;
    localparam int CWY   = ($clog2(MAX_HEIGHT + 1) > 10) ? $clog2(MAX_HEIGHT + 1) : 10;
    localparam int DW    = COORD_W;
    localparam int ERR_W = COORD_W + 3;
    localparam int E2_W  = ERR_W + 1;
    localparam int SUM_W = ODDS_W + 2;

    // configuration
    logic [GAIN_W-1:0] r_hit;
    logic [GAIN_W-1:0] r_miss;
    logic [SIZE_W-1:0] r_gw;
    logic [SIZE_W-1:0] r_gh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= HIT_ODDS_RST;
            r_miss <= MISS_ODDS_RST;
            r_gw   <= GRID_WIDTH_RST;
            r_gh   <= GRID_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HIT_ODDS:    r_hit  <= i_cfg_data[GAIN_W-1:0];
                CFG_MISS_ODDS:   r_miss <= i_cfg_data[GAIN_W-1:0];
                CFG_GRID_WIDTH:  r_gw   <= i_cfg_data[SIZE_W-1:0];
                CFG_GRID_HEIGHT: r_gh   <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // item registers
    logic [ACT_W-1:0]          r_act;
    logic                      r_in_range;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_ex;
    logic signed [COORD_W-1:0] r_ey;
    logic [DW-1:0]             r_dx;
    logic [DW-1:0]             r_dy;
    logic                      r_stx_neg;
    logic                      r_sty_neg;
    logic signed [ERR_W-1:0]   r_err;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [ODDS_W-1:0]  r_odds;
    logic signed [ODDS_W-1:0]  r_rdata;
    logic [AW-1:0]             r_clr_addr;
    logic signed [ODDS_W-1:0]  r_mem [DEPTH];

    // load-time differences
    logic signed [COORD_W:0] w_ddx;
    logic signed [COORD_W:0] w_ddy;
    logic [DW-1:0]           w_adx;
    logic [DW-1:0]           w_ady;

    assign w_ddx = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
    assign w_ddy = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
    assign w_adx = w_ddx[COORD_W] ? DW'(-w_ddx) : DW'(w_ddx);
    assign w_ady = w_ddy[COORD_W] ? DW'(-w_ddy) : DW'(w_ddy);

    // in-grid test and address
    logic [CWX-1:0] w_wlim;
    logic [CWY-1:0] w_hlim;
    logic           w_in_grid;
    logic [AW-1:0]  w_addr;

    assign w_wlim = (CWX'(r_gw) < CWX'(MAX_WIDTH))  ? CWX'(r_gw) : CWX'(MAX_WIDTH);
    assign w_hlim = (CWY'(r_gh) < CWY'(MAX_HEIGHT)) ? CWY'(r_gh) : CWY'(MAX_HEIGHT);
    assign w_in_grid = !r_x[COORD_W-1] && !r_y[COORD_W-1]
                    && (CWX'(r_x[COORD_W-2:0]) < w_wlim)
                    && (CWY'(r_y[COORD_W-2:0]) < w_hlim);
    assign w_addr = AW'(32'(r_y[COORD_W-2:0]) * 32'(MAX_WIDTH) + 32'(r_x[COORD_W-2:0]));

    // saturating cell arithmetic
    logic signed [SUM_W-1:0]  w_cell_ext;
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  w_diff;
    logic signed [ODDS_W-1:0] w_inc;
    logic signed [ODDS_W-1:0] w_dec;

    assign w_cell_ext = {{(SUM_W-ODDS_W){r_rdata[ODDS_W-1]}}, r_rdata};
    assign w_sum  = w_cell_ext + $signed({{(SUM_W-GAIN_W){1'b0}}, r_hit});
    assign w_diff = w_cell_ext - $signed({{(SUM_W-GAIN_W){1'b0}}, r_miss});
    assign w_inc  = (w_sum >= ODDS_MAX) ? ODDS_MAX : w_sum[ODDS_W-1:0];
    assign w_dec  = (w_diff > ODDS_MIN) ? w_diff[ODDS_W-1:0] : ODDS_MIN;

    // bresenham step
    logic signed [E2_W-1:0]    w_e2;
    logic signed [E2_W-1:0]    w_dx_e;
    logic signed [E2_W-1:0]    w_dy_e;
    logic                      w_step_x;
    logic                      w_step_y;
    logic signed [E2_W-1:0]    w_err_sum;
    logic signed [COORD_W-1:0] n_x;
    logic signed [COORD_W-1:0] n_y;
    logic signed [ERR_W-1:0]   n_err;

    assign w_e2     = {r_err, 1'b0};
    assign w_dx_e   = $signed({{(E2_W-DW){1'b0}}, r_dx});
    assign w_dy_e   = $signed({{(E2_W-DW){1'b0}}, r_dy});
    assign w_step_x = (w_e2 >= -w_dy_e);
    assign w_step_y = (w_e2 <= w_dx_e);
    assign w_err_sum = {r_err[ERR_W-1], r_err}
                     - (w_step_x ? w_dy_e : '0)
                     + (w_step_y ? w_dx_e : '0);
    assign n_err = w_err_sum[ERR_W-1:0];
    assign n_x = !w_step_x ? r_x : (r_stx_neg ? r_x - 11'sd1 : r_x + 11'sd1);
    assign n_y = !w_step_y ? r_y : (r_sty_neg ? r_y - 11'sd1 : r_y + 11'sd1);

    // memory write port
    logic                     w_pt_hit;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic signed [ODDS_W-1:0] w_wdata;

    assign w_pt_hit = w_in_grid && (r_act == ACT_ENDPOINT) && r_in_range;
    assign w_we     = i_cmd.clr || (i_cmd.pt_upd && w_pt_hit) || (i_cmd.ray_step && w_in_grid);
    assign w_waddr  = i_cmd.clr ? r_clr_addr : w_addr;
    assign w_wdata  = i_cmd.clr ? '0 : (i_cmd.ray_step ? w_dec : w_inc);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd && w_in_grid) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act      <= i_action;
            r_in_range <= i_endpoint_in_range;
            r_x        <= (i_action == ACT_ENDPOINT) ? i_end_x : i_start_x;
            r_y        <= (i_action == ACT_ENDPOINT) ? i_end_y : i_start_y;
            r_ex       <= i_end_x;
            r_ey       <= i_end_y;
            r_dx       <= w_adx;
            r_dy       <= w_ady;
            r_stx_neg  <= !(w_ddx > 0);
            r_sty_neg  <= !(w_ddy > 0);
            r_err      <= $signed({{(ERR_W-DW){1'b0}}, w_adx})
                        - $signed({{(ERR_W-DW){1'b0}}, w_ady});
            r_cnt      <= '0;
            r_odds     <= '0;
        end
        if (i_cmd.pt_upd) begin
            r_odds <= !w_in_grid ? '0 : (w_pt_hit ? w_inc : r_rdata);
            r_cnt  <= w_pt_hit ? CNT_W'(1) : '0;
        end
        if (i_cmd.ray_step) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_err <= n_err;
            if (w_in_grid) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            o_cell_odds     <= r_odds;
            o_cells_written <= r_cnt;
        end
    end

    assign o_status.clr_done    = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.at_end      = (r_x == r_ex) && (r_y == r_ey);
    assign o_status.next_at_end = (n_x == r_ex) && (n_y == r_ey);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ray_step |=> (r_cnt <= CNT_W'(2048)))
        else $error("ray wrote more cells than the longest walk");

    a_unit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ray_step |=>
            ($past(r_x) == r_x || $past(r_x) + 11'sd1 == r_x || $past(r_x) - 11'sd1 == r_x)
         && ($past(r_y) == r_y || $past(r_y) + 11'sd1 == r_y || $past(r_y) - 11'sd1 == r_y)
         && ($past(r_x) != r_x || $past(r_y) != r_y))
        else $error("walk did not move by one cell");

    a_odds_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we && !i_cmd.clr |-> (w_wdata != 8'sh80))
        else $error("cell written outside the clamped odds range");

endmodule

// File: sv/occupancy_grid_ray_update_top.sv
// ============================================================================
// occupancy_grid_ray_update_top: log-odds occupancy grid with ray tracing
// Top level joining the controller and the datapath.
// ============================================================================
// After reset the block clears its MAX_WIDTH x MAX_HEIGHT grid memory one cell
// per cycle and accepts no request until that pass ends; configuration writes
// are taken at any time. An endpoint or read request goes through a read and
// a write state; a ray request that visits n cells, the end cell left out,
// goes through a check state and then a read and a write state per cell on the
// grid memory. No new request is taken until its result is loaded, and every
// request returns exactly one result, which waits in an output register while
// the next request is accepted.
module occupancy_grid_ray_update_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ogru_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ogru_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [ogru_pkg::ACT_W-1:0]          i_action,
    input  logic signed [ogru_pkg::COORD_W-1:0] i_start_x,
    input  logic signed [ogru_pkg::COORD_W-1:0] i_start_y,
    input  logic signed [ogru_pkg::COORD_W-1:0] i_end_x,
    input  logic signed [ogru_pkg::COORD_W-1:0] i_end_y,
    input  logic                                i_endpoint_in_range,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ogru_pkg::ODDS_W-1:0]  o_cell_odds,
    output logic [ogru_pkg::CNT_W-1:0]          o_cells_written
);
    import ogru_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ogru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    ogru_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_action            (i_action),
        .i_start_x           (i_start_x),
        .i_start_y           (i_start_y),
        .i_end_x             (i_end_x),
        .i_end_y             (i_end_y),
        .i_endpoint_in_range (i_endpoint_in_range),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .o_cell_odds         (o_cell_odds),
        .o_cells_written     (o_cells_written)
    );

endmodule

// File: bench/testbench.sv
// ============================================================================
// testbench: self-checking bench for occupancy_grid_ray_update_top
// Drives endpoint, ray, read and unused requests through the request channel.
// A behavioral copy of the log-odds grid predicts every result but those of
// typed directed rows, and results are compared in order. A short directed
// table runs first, then randomized scans: endpoints first, then rays from a
// shared origin, then read-backs, mixed with noise. The scans run under
// several register settings and with gaps and stalls on both sides.
// ============================================================================
module testbench;
    import ogru_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int TIMEOUT_CYCLES = 12_000_000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int GRID_SPAN      = 256;
    localparam int REPORT_LIMIT   = 10;
    localparam int PHASE_ITEMS    = 62;
    localparam int COORD_MIN      = -1024;
    localparam int COORD_MAX      = 1023;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    localparam int PREDICT = 0;
    localparam int TYPED   = 1;

    localparam int NUM_DIRECTED = 25;
    localparam int ROW_W        = 9;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_W      = 5;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               in_range;
    } t_ray_request;

    typedef struct packed {
        logic [ODDS_W-1:0] odds;
        logic [CNT_W-1:0]  count;
    } t_cell_result;

    // action, start x/y, end x/y, in range, typed, odds, cells written
    int directed_table [0:NUM_DIRECTED*ROW_W-1] = '{
        ACT_READ,         0,     0,     0,    0, 0, TYPED,   0, 0,
        ACT_READ,       255,   255,     0,    0, 1, TYPED,   0, 0,
        ACT_READ,     -1024, -1024,  1023, 1023, 0, TYPED,   0, 0,
        ACT_READ,      1023,  1023, -1024,-1024, 1, TYPED,   0, 0,
        ACT_ENDPOINT,     7,     9,     0,    0, 1, TYPED,   3, 1,
        ACT_ENDPOINT,     7,     9,     0,    0, 0, TYPED,   3, 0,
        ACT_ENDPOINT,     0,     0,   256,    0, 1, TYPED,   0, 0,
        ACT_ENDPOINT,     0,     0,    -1,    5, 1, TYPED,   0, 0,
        ACT_ENDPOINT,     0,     0,   255,  255, 1, TYPED,   3, 1,
        ACT_ENDPOINT,     0,     0,     0,  255, 0, TYPED,   0, 0,
        ACT_UNUSED,      -1,    -1,    -1,   -1, 1, TYPED,   0, 0,
        ACT_UNUSED,    1023, -1024,     0,    5, 0, TYPED,   0, 0,
        ACT_RAY,         10,    10,    10,   10, 1, TYPED,   0, 0,
        ACT_RAY,          0,     0,     5,    0, 0, TYPED,   0, 5,
        ACT_READ,         0,     0,     0,    0, 0, TYPED,   2, 0,
        ACT_READ,         5,     0,     0,    0, 0, TYPED,   0, 0,
        ACT_RAY,         -5,    -5,     5,    5, 1, PREDICT, 0, 0,
        ACT_RAY,      -1024, -1024,  1023, 1023, 0, PREDICT, 0, 0,
        ACT_RAY,          3,   -20,     7,  300, 1, PREDICT, 0, 0,
        ACT_RAY,        255,   100,    -3,  100, 0, PREDICT, 0, 0,
        ACT_RAY,       1023,     0, -1024,    7, 1, PREDICT, 0, 0,
        ACT_READ,         4,     4,     0,    0, 0, PREDICT, 0, 0,
        ACT_READ,       255,   255,     0,    0, 1, PREDICT, 0, 0,
        ACT_ENDPOINT,     0,     0, -1024, 1023, 1, TYPED,   0, 0,
        ACT_READ,       100,   100,     0,    0, 0, PREDICT, 0, 0
    };

    // hit odds, miss odds, grid width, grid height, idling
    int phase_setup [0:NUM_PHASES*PHASE_W-1] = '{
          3,   1, 256, 256, IDLE_NONE,
        127,   0, 256, 256, IDLE_SEND,
          0, 127, 256, 256, IDLE_RECV,
         20,   5,   1,   1, IDLE_BOTH,
         64,  33, 300,  17, IDLE_NONE,
        127, 127,   0, 256, IDLE_SEND,
          9,   2, 256, 511, IDLE_RECV,
          5,   3,  40, 200, IDLE_BOTH
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [ACT_W-1:0]    i_action;
    logic signed [COORD_W-1:0] i_start_x;
    logic signed [COORD_W-1:0] i_start_y;
    logic signed [COORD_W-1:0] i_end_x;
    logic signed [COORD_W-1:0] i_end_y;
    logic                i_endpoint_in_range;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic signed [ODDS_W-1:0] o_cell_odds;
    logic [CNT_W-1:0]    o_cells_written;

    logic signed [ODDS_W-1:0] odds_map [0:GRID_SPAN*GRID_SPAN-1];
    logic [GAIN_W-1:0]   hit_odds_q;
    logic [GAIN_W-1:0]   miss_odds_q;
    logic [SIZE_W-1:0]   grid_w_q;
    logic [SIZE_W-1:0]   grid_h_q;

    t_cell_result odds_results_due [$];

    int mismatches      = 0;
    int results_checked = 0;
    int ray_cells_total = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int action_seen [0:3] = '{0, 0, 0, 0};

    occupancy_grid_ray_update_top i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_action            (i_action),
        .i_start_x           (i_start_x),
        .i_start_y           (i_start_y),
        .i_end_x             (i_end_x),
        .i_end_y             (i_end_y),
        .i_endpoint_in_range (i_endpoint_in_range),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_cell_odds         (o_cell_odds),
        .o_cells_written     (o_cells_written)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD/2) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results outstanding", odds_results_due.size());
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic int clip_coord(input int v);
        return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
    endfunction

    function automatic int rand_offset(input int reach);
        return int'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    function automatic t_ray_request make_request(input int action, input int sx,
                                                  input int sy, input int ex,
                                                  input int ey, input int rng);
        t_ray_request r;
        r.action   = action[ACT_W-1:0];
        r.start_x  = sx[COORD_W-1:0];
        r.start_y  = sy[COORD_W-1:0];
        r.end_x    = ex[COORD_W-1:0];
        r.end_y    = ey[COORD_W-1:0];
        r.in_range = rng[0];
        return r;
    endfunction

    function automatic bit cell_inside(input int x, input int y);
        int w;
        int h;
        w = (grid_w_q < GRID_SPAN) ? int'(grid_w_q) : GRID_SPAN;
        h = (grid_h_q < GRID_SPAN) ? int'(grid_h_q) : GRID_SPAN;
        return x >= 0 && y >= 0 && x < w && y < h;
    endfunction

    function automatic int cell_index(input int x, input int y);
        return y * GRID_SPAN + x;
    endfunction

    // updates the grid copy and returns the result the block should give
    function automatic t_cell_result update_odds_map(input t_ray_request req);
        t_cell_result res;
        int sx, sy, ex, ey;
        int dx, dy, stx, sty, err, e2, x, y, guard, v, cnt;
        sx  = $signed(req.start_x);
        sy  = $signed(req.start_y);
        ex  = $signed(req.end_x);
        ey  = $signed(req.end_y);
        cnt = 0;
        res.odds = '0;
        case (req.action)
            ACT_ENDPOINT: begin
                if (cell_inside(ex, ey)) begin
                    if (req.in_range) begin
                        v = odds_map[cell_index(ex, ey)] + int'(hit_odds_q);
                        if (v >= int'(ODDS_MAX)) v = int'(ODDS_MAX);
                        odds_map[cell_index(ex, ey)] = v[ODDS_W-1:0];
                        cnt = 1;
                    end
                    res.odds = odds_map[cell_index(ex, ey)];
                end
            end
            ACT_RAY: begin
                dx    = (ex > sx) ? ex - sx : sx - ex;
                dy    = (ey > sy) ? ey - sy : sy - ey;
                stx   = (sx < ex) ? 1 : -1;
                sty   = (sy < ey) ? 1 : -1;
                err   = dx - dy;
                x     = sx;
                y     = sy;
                guard = dx + dy + 1;
                while ((x != ex || y != ey) && guard > 0) begin
                    e2 = err * 2;
                    guard--;
                    if (cell_inside(x, y)) begin
                        v = odds_map[cell_index(x, y)] - int'(miss_odds_q);
                        if (v < int'(ODDS_MIN)) v = int'(ODDS_MIN);
                        odds_map[cell_index(x, y)] = v[ODDS_W-1:0];
                        cnt++;
                    end
                    if (e2 >= -dy) begin
                        err -= dy;
                        x += stx;
                    end
                    if (e2 <= dx) begin
                        err += dx;
                        y += sty;
                    end
                end
            end
            ACT_READ: begin
                if (cell_inside(sx, sy)) res.odds = odds_map[cell_index(sx, sy)];
            end
            default: begin
            end
        endcase
        res.count = cnt[CNT_W-1:0];
        return res;
    endfunction

    task automatic send_request(input t_ray_request req, input bit typed,
                                input t_cell_result typed_res);
        t_cell_result res;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid          <= 1'b1;
        i_action            <= req.action;
        i_start_x           <= req.start_x;
        i_start_y           <= req.start_y;
        i_end_x             <= req.end_x;
        i_end_y             <= req.end_y;
        i_endpoint_in_range <= req.in_range;
        do @(posedge i_clk); while (!o_in_ready);
        res = update_odds_map(req);
        odds_results_due.insert(odds_results_due.size(), typed ? typed_res : res);
        action_seen[req.action]++;
        if (req.action == ACT_RAY) ray_cells_total += res.count;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value[CFG_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HIT_ODDS:    hit_odds_q  = value[GAIN_W-1:0];
            CFG_MISS_ODDS:   miss_odds_q = value[GAIN_W-1:0];
            CFG_GRID_WIDTH:  grid_w_q    = value[SIZE_W-1:0];
            CFG_GRID_HEIGHT: grid_h_q    = value[SIZE_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (odds_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (odds_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: odds %0d cells %0d",
                             o_cell_odds, o_cells_written);
            end else begin
                want = odds_results_due.pop_front();
                if (o_cell_odds !== want.odds || o_cells_written !== want.count) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d: expected odds %0d cells %0d, got %0d / %0d",
                                 results_checked, $signed(want.odds), want.count,
                                 o_cell_odds, o_cells_written);
                end
            end
        end
    end

    initial begin
        t_ray_request req;
        t_cell_result typed_res;
        int base, ph, mode, items, n, k, r, nr, pick, reach;
        int ox, oy, span_w, span_h, act, sx, sy, ex, ey, want_odds, want_cnt;
        int tx [0:7];
        int ty [0:7];

        i_rst_n             <= 1'b0;
        i_cfg_valid         <= 1'b0;
        i_cfg_index         <= CFG_HIT_ODDS;
        i_cfg_data          <= '0;
        i_in_valid          <= 1'b0;
        i_action            <= ACT_ENDPOINT;
        i_start_x           <= '0;
        i_start_y           <= '0;
        i_end_x             <= '0;
        i_end_y             <= '0;
        i_endpoint_in_range <= 1'b0;

        for (int i = 0; i < GRID_SPAN * GRID_SPAN; i++) odds_map[i] = '0;
        hit_odds_q  = HIT_ODDS_RST;
        miss_odds_q = MISS_ODDS_RST;
        grid_w_q    = GRID_WIDTH_RST;
        grid_h_q    = GRID_HEIGHT_RST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the reset register values
        for (int row = 0; row < NUM_DIRECTED; row++) begin
            base = row * ROW_W;
            req = make_request(directed_table[base], directed_table[base+1],
                               directed_table[base+2], directed_table[base+3],
                               directed_table[base+4], directed_table[base+5]);
            want_odds       = directed_table[base+7];
            want_cnt        = directed_table[base+8];
            typed_res.odds  = want_odds[ODDS_W-1:0];
            typed_res.count = want_cnt[CNT_W-1:0];
            send_request(req, directed_table[base+6] == TYPED, typed_res);
        end
        wait_for_results();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            base = ph * PHASE_W;
            write_reg(CFG_HIT_ODDS,    phase_setup[base]);
            write_reg(CFG_MISS_ODDS,   phase_setup[base+1]);
            write_reg(CFG_GRID_WIDTH,  phase_setup[base+2]);
            write_reg(CFG_GRID_HEIGHT, phase_setup[base+3]);
            i_cfg_valid <= 1'b0;

            mode = phase_setup[base+4];
            send_idle_pct = (mode == IDLE_SEND) ? 55 : ((mode == IDLE_BOTH) ? 8 : 0);
            recv_stall_pct <= (mode == IDLE_RECV) ? 55 : ((mode == IDLE_BOTH) ? 8 : 0);

            span_w = (grid_w_q > GRID_SPAN) ? GRID_SPAN : int'(grid_w_q);
            span_h = (grid_h_q > GRID_SPAN) ? GRID_SPAN : int'(grid_h_q);
            items = 0;
            while (items < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15) begin
                    // noise: any action, coordinates over the whole field range
                    act = $urandom_range(0, 3);
                    sx  = rand_coord();
                    sy  = rand_coord();
                    if (act == ACT_RAY && $urandom_range(9) != 0) begin
                        ex = clip_coord(sx + rand_offset(20));
                        ey = clip_coord(sy + rand_offset(20));
                    end else begin
                        ex = rand_coord();
                        ey = rand_coord();
                    end
                    send_request(make_request(act, sx, sy, ex, ey, $urandom_range(1)),
                                 1'b0, '0);
                    items++;
                end else begin
                    // one scan: endpoints, then rays from the same origin, then reads
                    ox = int'($urandom_range(0, span_w + 9)) - 5;
                    oy = int'($urandom_range(0, span_h + 9)) - 5;
                    n  = $urandom_range(1, 6);
                    for (k = 0; k < n; k++) begin
                        pick  = $urandom_range(99);
                        reach = (pick < 85) ? 24 : ((pick < 97) ? 300 : 0);
                        if (reach > 0) begin
                            tx[k] = clip_coord(ox + rand_offset(reach));
                            ty[k] = clip_coord(oy + rand_offset(reach));
                        end else begin
                            tx[k] = rand_coord();
                            ty[k] = rand_coord();
                        end
                    end
                    for (k = 0; k < n; k++)
                        send_request(make_request(ACT_ENDPOINT, ox, oy, tx[k], ty[k],
                                                  $urandom_range(99) < 80), 1'b0, '0);
                    for (k = 0; k < n; k++)
                        send_request(make_request(ACT_RAY, ox, oy, tx[k], ty[k],
                                                  $urandom_range(1)), 1'b0, '0);
                    nr = $urandom_range(1, 2);
                    for (r = 0; r < nr; r++) begin
                        k = $urandom_range(0, n - 1);
                        if ($urandom_range(1) != 0) begin
                            sx = tx[k];
                            sy = ty[k];
                        end else begin
                            sx = (ox + tx[k]) / 2;
                            sy = (oy + ty[k]) / 2;
                        end
                        send_request(make_request(ACT_READ, sx, sy, rand_coord(), rand_coord(),
                                                  $urandom_range(1)), 1'b0, '0);
                    end
                    items += 2 * n + nr;
                end
            end
            wait_for_results();
        end

        $display("covered %0d endpoint, %0d ray, %0d read, %0d unused requests",
                 action_seen[ACT_ENDPOINT], action_seen[ACT_RAY], action_seen[ACT_READ],
                 action_seen[ACT_UNUSED]);
        $display("%0d register settings, %0d results checked, %0d free cells, %0d mismatches",
                 NUM_PHASES + 1, results_checked, ray_cells_total, mismatches);
        if (mismatches == 0 && odds_results_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
